// File: hdl/msu_pkg.sv
// ----------------------------------------------------------------------------
// Motor start-up sequencer package
// Shared types and constants: configuration register indexes, the input and
// result transaction layouts and the configuration bundle.
// ----------------------------------------------------------------------------
package msu_pkg;

  localparam int unsigned TICK_W     = 20;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned TURN_W     = 32;
  localparam int unsigned ACCEL_W    = 24;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_CURRENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_CURRENT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ACCEL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP     = 3'd7;

  // Reset values of the configuration registers that do not reset to zero.
  localparam logic [TICK_W-1:0]  RST_ALIGN_TICKS = 20'd1000;
  localparam logic [TICK_W-1:0]  RST_RAMP_TICKS  = 20'd20000;
  localparam logic [TICK_W-1:0]  RST_HOLD_TICKS  = 20'd20000;
  localparam logic [ANGLE_W-1:0] RST_ALIGN_ANGLE = 16'd16384;

  typedef struct packed {
    logic                      run;
    logic [ANGLE_W-1:0]        encoder_angle;
    logic signed [CUR_W-1:0]   speed_loop_out;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic signed [CUR_W-1:0]   id_ref;
    logic signed [CUR_W-1:0]   iq_ref;
    logic [ANGLE_W-1:0]        angle_ref;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]         align_ticks;
    logic [TICK_W-1:0]         ramp_ticks;
    logic [TICK_W-1:0]         hold_ticks;
    logic [ANGLE_W-1:0]        first_align_angle;
    logic signed [CUR_W-1:0]   align_current;
    logic signed [CUR_W-1:0]   ramp_current;
    logic [ACCEL_W-1:0]        ramp_accel;
    logic [TURN_W-1:0]         hold_step;
  } cfg_t;

endpackage

// File: hdl/motor_if_startup_sequencer_core.sv
// ----------------------------------------------------------------------------
// Motor start-up sequencer core
// Open-loop start-up sequencer for a PMSM current controller: alignment,
// accelerating ramp, constant-speed hold and hand-over to closed loop.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick and produces exactly one result
// transaction. The block takes one transaction per clock cycle when the
// result side does not stall. A result passes from the input register into
// the result register, which presents it on the result channel; a stall on
// the result side can hold it in the input register. The throughput is set
// by the phase state machine and the 32-bit angle and speed accumulators,
// whose feedback loops are not pipelined.
// Configuration registers are written through the cfg_ port and should only
// be changed while no transaction is in flight.
module motor_if_startup_sequencer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  msu_pkg::in_item_t                in_data,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output msu_pkg::out_item_t               out_data,
  // Configuration port.
  input  logic                             cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  msu_pkg::cfg_t      cfg;
  msu_pkg::in_item_t  in_data_r;
  msu_pkg::out_item_t out_data_r;
  msu_pkg::out_item_t step_result;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               advance;

  // The input register moves into the result register whenever the result
  // register is empty or its transaction is being taken in this cycle.
  // The step logic updates its state at that same edge, so the next tick
  // always sees the state left by the previous one.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  msu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  msu_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/msu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Motor start-up sequencer configuration registers
// Write-only register file decoded from the configuration port.
// ----------------------------------------------------------------------------
module msu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output msu_pkg::cfg_t                    cfg
);

  msu_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align_ticks       <= msu_pkg::RST_ALIGN_TICKS;
      cfg_r.ramp_ticks        <= msu_pkg::RST_RAMP_TICKS;
      cfg_r.hold_ticks        <= msu_pkg::RST_HOLD_TICKS;
      cfg_r.first_align_angle <= msu_pkg::RST_ALIGN_ANGLE;
      cfg_r.align_current     <= '0;
      cfg_r.ramp_current      <= '0;
      cfg_r.ramp_accel        <= '0;
      cfg_r.hold_step         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msu_pkg::REG_ALIGN_TICKS:   cfg_r.align_ticks <= cfg_wdata[msu_pkg::TICK_W-1:0];
        msu_pkg::REG_RAMP_TICKS:    cfg_r.ramp_ticks  <= cfg_wdata[msu_pkg::TICK_W-1:0];
        msu_pkg::REG_HOLD_TICKS:    cfg_r.hold_ticks  <= cfg_wdata[msu_pkg::TICK_W-1:0];
        msu_pkg::REG_ALIGN_ANGLE:
          cfg_r.first_align_angle <= cfg_wdata[msu_pkg::ANGLE_W-1:0];
        msu_pkg::REG_ALIGN_CURRENT: cfg_r.align_current <= cfg_wdata[msu_pkg::CUR_W-1:0];
        msu_pkg::REG_RAMP_CURRENT:  cfg_r.ramp_current  <= cfg_wdata[msu_pkg::CUR_W-1:0];
        msu_pkg::REG_RAMP_ACCEL:    cfg_r.ramp_accel    <= cfg_wdata[msu_pkg::ACCEL_W-1:0];
        msu_pkg::REG_HOLD_STEP:     cfg_r.hold_step     <= cfg_wdata[msu_pkg::TURN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/msu_step.sv
// ----------------------------------------------------------------------------
// Motor start-up sequencer step logic
// Phase state machine, saturating tick counter and the open-loop speed and
// angle accumulators. Forms one result per stepped transaction.
// ----------------------------------------------------------------------------
module msu_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  msu_pkg::in_item_t     item,
  input  msu_pkg::cfg_t         cfg,
  output msu_pkg::out_item_t    result
);

  typedef enum logic [msu_pkg::PHASE_W-1:0] {
    MODE_IDLE   = 3'd0,
    MODE_ALIGN1 = 3'd1,
    MODE_ALIGN2 = 3'd2,
    MODE_RAMP   = 3'd3,
    MODE_HOLD   = 3'd4,
    MODE_FOC    = 3'd5
  } mode_t;

  mode_t                       mode_r, mode_nxt, ph;
  logic [msu_pkg::TICK_W-1:0]  tick_r, tick_nxt, tick_inc;
  logic [msu_pkg::TURN_W-1:0]  speed_r, speed_nxt;
  logic [msu_pkg::TURN_W-1:0]  accum_r, accum_nxt;
  logic                        ramp_done;
  logic                        align_done;
  logic                        hold_done;

  assign tick_inc   = (&tick_r) ? tick_r : tick_r + 1'b1;
  assign align_done = (tick_inc >= cfg.align_ticks);
  assign ramp_done  = (tick_inc >= cfg.ramp_ticks);
  assign hold_done  = (tick_inc >= cfg.hold_ticks);

  // Phase decision. The reported phase lags the mode only when the first
  // alignment ends.
  always_comb begin
    mode_nxt = mode_r;
    ph       = mode_r;
    tick_nxt = tick_inc;
    unique case (mode_r)
      MODE_ALIGN1: begin
        if (align_done) begin
          tick_nxt = '0;
          mode_nxt = MODE_ALIGN2;
        end else if (!item.run) begin
          mode_nxt = MODE_IDLE;
          ph       = MODE_IDLE;
        end
      end
      MODE_ALIGN2: begin
        if (align_done) begin
          tick_nxt = '0;
          mode_nxt = MODE_RAMP;
          ph       = MODE_RAMP;
        end else if (!item.run) begin
          mode_nxt = MODE_IDLE;
          ph       = MODE_IDLE;
        end
      end
      MODE_RAMP: begin
        if (ramp_done) begin
          tick_nxt = '0;
          mode_nxt = MODE_HOLD;
          ph       = MODE_HOLD;
        end else if (!item.run) begin
          mode_nxt = MODE_IDLE;
          ph       = MODE_IDLE;
        end
      end
      MODE_HOLD: begin
        if (hold_done) begin
          tick_nxt = '0;
          mode_nxt = MODE_FOC;
          ph       = MODE_FOC;
        end
        if (!item.run) begin
          mode_nxt = MODE_IDLE;
          ph       = MODE_IDLE;
        end
      end
      MODE_FOC: begin
        if (!item.run) begin
          mode_nxt = MODE_IDLE;
          ph       = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        ph       = MODE_IDLE;
        if (item.run) begin
          tick_nxt = '0;
          mode_nxt = MODE_ALIGN1;
          ph       = MODE_ALIGN1;
        end
      end
    endcase
  end

  // Outputs and accumulator updates for the reported phase.
  always_comb begin
    speed_nxt        = speed_r;
    accum_nxt        = accum_r;
    result.phase     = ph;
    result.id_ref    = '0;
    result.iq_ref    = '0;
    result.angle_ref = '0;
    case (ph)
      MODE_ALIGN1: begin
        result.angle_ref = cfg.first_align_angle;
        result.id_ref    = cfg.align_current;
      end
      MODE_ALIGN2: begin
        result.id_ref = cfg.align_current;
        speed_nxt     = '0;
      end
      MODE_RAMP: begin
        result.angle_ref = accum_r[msu_pkg::TURN_W-1 -: msu_pkg::ANGLE_W];
        result.iq_ref    = cfg.ramp_current;
        speed_nxt        = speed_r + {{(msu_pkg::TURN_W-msu_pkg::ACCEL_W){1'b0}},
                                      cfg.ramp_accel};
        accum_nxt        = accum_r + speed_r;
      end
      MODE_HOLD: begin
        result.angle_ref = accum_r[msu_pkg::TURN_W-1 -: msu_pkg::ANGLE_W];
        result.iq_ref    = cfg.ramp_current;
        accum_nxt        = accum_r + cfg.hold_step;
      end
      MODE_FOC: begin
        result.angle_ref = item.encoder_angle;
        result.iq_ref    = item.speed_loop_out;
      end
      default: begin
        speed_nxt = '0;
        accum_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      tick_r  <= '0;
      speed_r <= '0;
      accum_r <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
      speed_r <= speed_nxt;
      accum_r <= accum_nxt;
    end
  end

  // A tick reported as idle leaves both accumulators cleared.
  a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (result.phase == MODE_IDLE) |=> (speed_r == '0) && (accum_r == '0))
    else $error("accumulators not cleared by an idle tick");

  // A start request in idle enters the first alignment with a fresh count.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (mode_r == MODE_IDLE) && item.run |=>
      (mode_r == MODE_ALIGN1) && (tick_r == '0))
    else $error("start request did not enter first alignment");

  // A stop during hold always wins over the move to closed loop.
  a_hold_stop: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (mode_r == MODE_HOLD) && !item.run |=> (mode_r == MODE_IDLE))
    else $error("stop in hold did not return to idle");

  // Closed loop persists while run stays high.
  a_foc_keep: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (mode_r == MODE_FOC) && item.run |=> (mode_r == MODE_FOC))
    else $error("closed loop left while running");

endmodule
